/* rtl/fuzzy_gain_scheduled_pid_macros.svh */
// Assertion macros shared by the fuzzy gain-scheduled PID controller.
`ifndef FUZZY_GAIN_SCHEDULED_PID_MACROS_SVH
`define FUZZY_GAIN_SCHEDULED_PID_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FGSP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FGSP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/fgsp_pkg.sv */
// Types, constants and helper functions of the fuzzy gain-scheduled PID controller.
package fgsp_pkg;

	localparam int ERR_WIDTH   = 16;
	localparam int ACC_WIDTH   = 32;
	localparam int DRIVE_WIDTH = 36;

	localparam int GP_W = 3;
	localparam int GI_W = 2;
	localparam int GD_W = 2;
	localparam int QUO_W = 3;

	localparam int IN_TDATA_W  = ((2 * ERR_WIDTH + 7) / 8) * 8;
	localparam int OUT_BITS    = DRIVE_WIDTH + GP_W + GI_W + GD_W;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	// Fuzzy span and membership, weight, numerator and denominator widths.
	localparam int FUZZ_SPAN = 20;
	localparam int MEM_W     = 5;
	localparam int DEN_W     = 6;
	localparam int NUM_W     = 9;

	localparam int KP_S = 2;
	localparam int KP_M = 4;
	localparam int KP_L = 6;
	localparam int KI_S = 1;
	localparam int KI_M = 2;
	localparam int KI_L = 3;
	localparam int KD_S = 1;
	localparam int KD_M = 2;
	localparam int KD_L = 3;

	// Queue between front and back; the depth is a power of two.
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = 1;
	localparam int FIFO_CNT_W = 2;

	// Integral update width and its saturation bounds.
	localparam int ISUM_W = ((ERR_WIDTH > ACC_WIDTH) ? ERR_WIDTH : ACC_WIDTH) + 1;
	localparam logic signed [ISUM_W-1:0] ACC_MAX =
		{{(ISUM_W-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
	localparam logic signed [ISUM_W-1:0] ACC_MIN =
		{{(ISUM_W-ACC_WIDTH+1){1'b1}}, {(ACC_WIDTH-1){1'b0}}};

	// Product widths and the drive sum width with its saturation bounds.
	localparam int PP_W = ERR_WIDTH + GP_W + 1;
	localparam int PI_W = ACC_WIDTH + GI_W + 1;
	localparam int PD_W = ERR_WIDTH + GD_W + 1;
	localparam int PMAX_W = (PI_W > PP_W) ? ((PI_W > PD_W) ? PI_W : PD_W)
	                                      : ((PP_W > PD_W) ? PP_W : PD_W);
	localparam int DRV_W = (PMAX_W + 2 > DRIVE_WIDTH + 1) ? PMAX_W + 2 : DRIVE_WIDTH + 1;
	localparam logic signed [DRV_W-1:0] DRIVE_MAX =
		{{(DRV_W-DRIVE_WIDTH+1){1'b0}}, {(DRIVE_WIDTH-1){1'b1}}};
	localparam logic signed [DRV_W-1:0] DRIVE_MIN =
		{{(DRV_W-DRIVE_WIDTH+1){1'b1}}, {(DRIVE_WIDTH-1){1'b0}}};

	typedef struct packed {
		logic [MEM_W-1:0] n;
		logic [MEM_W-1:0] z;
		logic [MEM_W-1:0] p;
	} fgsp_mem_t;

	// One classified sample on its way from front to back.
	typedef struct packed {
		logic signed [ERR_WIDTH-1:0] e;
		logic signed [ERR_WIDTH-1:0] de;
		logic [NUM_W-1:0]            num_p;
		logic [NUM_W-1:0]            num_i;
		logic [NUM_W-1:0]            num_d;
		logic [DEN_W-1:0]            den;
	} fgsp_item_t;

	typedef struct packed {
		logic [FIFO_CNT_W-1:0] level;
		logic                  full;
		logic                  empty;
	} fgsp_fifo_st_t;

	// Negative, zero and positive memberships of one value.
	function automatic fgsp_mem_t fgsp_fuzzify(input logic signed [ERR_WIDTH-1:0] x);
		fgsp_mem_t m;
		logic [MEM_W-1:0] lo;
		logic [MEM_W-1:0] span;
		logic signed [ERR_WIDTH-1:0] span_pos;
		logic signed [ERR_WIDTH-1:0] span_neg;
		m        = '0;
		lo       = x[MEM_W-1:0];
		span     = MEM_W'(FUZZ_SPAN);
		span_pos = ERR_WIDTH'(FUZZ_SPAN);
		span_neg = -span_pos;
		if (x <= span_neg) begin
			m.n = span;
		end else if (x >= span_pos) begin
			m.p = span;
		end else if (!x[ERR_WIDTH-1]) begin
			m.p = lo;
			m.z = span - lo;
		end else begin
			m.n = MEM_W'(0) - lo;
			m.z = span + lo;
		end
		return m;
	endfunction

	function automatic logic [MEM_W-1:0] fgsp_min(input logic [MEM_W-1:0] a,
	                                              input logic [MEM_W-1:0] b);
		return (a < b) ? a : b;
	endfunction

	function automatic logic [MEM_W-1:0] fgsp_max(input logic [MEM_W-1:0] a,
	                                              input logic [MEM_W-1:0] b);
		return (a > b) ? a : b;
	endfunction

endpackage

/* rtl/fgsp_front.sv */
// Front part: takes a sample, fuzzifies it and forms the defuzzification sums.
module fgsp_front
	import fgsp_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic signed [ERR_WIDTH-1:0] in_e,
	input  logic signed [ERR_WIDTH-1:0] in_de,
	output logic                        push_valid,
	input  logic                        push_ready,
	output fgsp_item_t                  push_item
);

	logic                        valid_s1;
	logic signed [ERR_WIDTH-1:0] e_s1;
	logic signed [ERR_WIDTH-1:0] de_s1;

	fgsp_mem_t        me;
	fgsp_mem_t        md;
	logic [MEM_W-1:0] m00, m01, m10, m11, m12, m21, m22;
	logic [MEM_W-1:0] wa, wb, wc;

	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			e_s1  <= in_e;
			de_s1 <= in_de;
		end
	end

	always_comb begin
		me  = fgsp_fuzzify(e_s1);
		md  = fgsp_fuzzify(de_s1);
		m00 = fgsp_min(me.n, md.n);
		m01 = fgsp_min(me.n, md.z);
		m10 = fgsp_min(me.z, md.n);
		m11 = fgsp_min(me.z, md.z);
		m12 = fgsp_min(me.z, md.p);
		m21 = fgsp_min(me.p, md.z);
		m22 = fgsp_min(me.p, md.p);
		wa  = fgsp_max(m00, m01);
		wb  = fgsp_max(m21, m22);
		wc  = fgsp_max(fgsp_max(m01, m10), fgsp_max(fgsp_max(m11, m12), m21));

		push_item.e     = e_s1;
		push_item.de    = de_s1;
		push_item.den   = DEN_W'(wa) + DEN_W'(wb) + DEN_W'(wc);
		push_item.num_p = NUM_W'(KP_S) * NUM_W'(wa) + NUM_W'(KP_M) * NUM_W'(wc)
		                + NUM_W'(KP_L) * NUM_W'(wb);
		push_item.num_i = NUM_W'(KI_S) * NUM_W'(wa) + NUM_W'(KI_M) * NUM_W'(wc)
		                + NUM_W'(KI_L) * NUM_W'(wb);
		push_item.num_d = NUM_W'(KD_S) * NUM_W'(wb) + NUM_W'(KD_M) * NUM_W'(wc)
		                + NUM_W'(KD_L) * NUM_W'(wa);
	end

endmodule

/* rtl/fgsp_fifo.sv */
// Short queue that decouples the front part from the back part.
module fgsp_fifo
	import fgsp_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  fgsp_item_t    push_item,
	output logic          pop_valid,
	input  logic          pop_ready,
	output fgsp_item_t    pop_item,
	output fgsp_fifo_st_t status
);

	fgsp_item_t            mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic                  do_push;
	logic                  do_pop;

	assign status.level = count_q;
	assign status.full  = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign status.empty = (count_q == '0);
	assign push_ready   = !status.full;
	assign pop_valid    = !status.empty;
	assign pop_item     = mem_q[rd_ptr_q];
	assign do_push      = push_valid && push_ready;
	assign do_pop       = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

/* rtl/fgsp_back.sv */
// Back part: divides out the gains, updates the integral and forms the drive.
module fgsp_back
	import fgsp_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pop_valid,
	output logic                          pop_ready,
	input  fgsp_item_t                    pop_item,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [DRIVE_WIDTH-1:0] out_drive,
	output logic [GP_W-1:0]               out_gain_p,
	output logic [GI_W-1:0]               out_gain_i,
	output logic [GD_W-1:0]               out_gain_d
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DIV   = 3'd1;
	localparam logic [2:0] ST_INTEG = 3'd2;
	localparam logic [2:0] ST_MUL   = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	logic [2:0]                state_q;
	logic [1:0]                cnt_q;
	fgsp_item_t                item_q;
	logic [NUM_W-1:0]          rem_p_q, rem_i_q, rem_d_q;
	logic [QUO_W-1:0]          quo_p_q, quo_i_q, quo_d_q;
	logic [GP_W-1:0]           held_p_q;
	logic [GI_W-1:0]           held_i_q;
	logic [GD_W-1:0]           held_d_q;
	logic signed [ACC_WIDTH-1:0] integral_q;
	logic signed [PP_W-1:0]    prod_p_s2;
	logic signed [PI_W-1:0]    prod_i_s2;
	logic signed [PD_W-1:0]    prod_d_s2;
	logic                      out_valid_q;

	logic [NUM_W-1:0]          dshift;
	logic                      ge_p, ge_i, ge_d;
	logic signed [ISUM_W-1:0]  isum;
	logic signed [ACC_WIDTH-1:0] isat;
	logic signed [DRV_W-1:0]   dsum;
	logic signed [DRIVE_WIDTH-1:0] dsat;
	logic                      out_free;

	assign pop_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	// One quotient bit per cycle for all three gains.
	always_comb begin
		dshift = NUM_W'(item_q.den) << cnt_q;
		ge_p   = (rem_p_q >= dshift);
		ge_i   = (rem_i_q >= dshift);
		ge_d   = (rem_d_q >= dshift);
	end

	always_comb begin
		isum = {{(ISUM_W-ACC_WIDTH){integral_q[ACC_WIDTH-1]}}, integral_q}
		     + {{(ISUM_W-ERR_WIDTH){item_q.e[ERR_WIDTH-1]}}, item_q.e};
		if (isum > ACC_MAX) begin
			isat = ACC_MAX[ACC_WIDTH-1:0];
		end else if (isum < ACC_MIN) begin
			isat = ACC_MIN[ACC_WIDTH-1:0];
		end else begin
			isat = isum[ACC_WIDTH-1:0];
		end
	end

	always_comb begin
		dsum = {{(DRV_W-PP_W){prod_p_s2[PP_W-1]}}, prod_p_s2}
		     + {{(DRV_W-PI_W){prod_i_s2[PI_W-1]}}, prod_i_s2}
		     + {{(DRV_W-PD_W){prod_d_s2[PD_W-1]}}, prod_d_s2};
		if (dsum > DRIVE_MAX) begin
			dsat = DRIVE_MAX[DRIVE_WIDTH-1:0];
		end else if (dsum < DRIVE_MIN) begin
			dsat = DRIVE_MIN[DRIVE_WIDTH-1:0];
		end else begin
			dsat = dsum[DRIVE_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			held_p_q    <= '0;
			held_i_q    <= '0;
			held_d_q    <= '0;
			integral_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// In the output state the valid flag is set below instead.
			if (out_valid_q && out_ready && state_q != ST_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						cnt_q   <= 2'd2;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == 2'd0) begin
						state_q <= ST_INTEG;
					end
				end
				ST_INTEG: begin
					if (item_q.den != '0) begin
						held_p_q <= quo_p_q[GP_W-1:0];
						held_i_q <= quo_i_q[GI_W-1:0];
						held_d_q <= quo_d_q[GD_W-1:0];
					end
					integral_q <= isat;
					state_q    <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && pop_valid) begin
			item_q  <= pop_item;
			rem_p_q <= pop_item.num_p;
			rem_i_q <= pop_item.num_i;
			rem_d_q <= pop_item.num_d;
			quo_p_q <= '0;
			quo_i_q <= '0;
			quo_d_q <= '0;
		end
		if (state_q == ST_DIV) begin
			if (ge_p) begin
				rem_p_q <= rem_p_q - dshift;
			end
			if (ge_i) begin
				rem_i_q <= rem_i_q - dshift;
			end
			if (ge_d) begin
				rem_d_q <= rem_d_q - dshift;
			end
			quo_p_q[cnt_q] <= ge_p;
			quo_i_q[cnt_q] <= ge_i;
			quo_d_q[cnt_q] <= ge_d;
		end
		if (state_q == ST_MUL) begin
			prod_p_s2 <= $signed({1'b0, held_p_q}) * item_q.e;
			prod_i_s2 <= $signed({1'b0, held_i_q}) * integral_q;
			prod_d_s2 <= $signed({1'b0, held_d_q}) * item_q.de;
		end
		if (state_q == ST_OUT && out_free) begin
			out_drive  <= dsat;
			out_gain_p <= held_p_q;
			out_gain_i <= held_i_q;
			out_gain_d <= held_d_q;
		end
	end

endmodule

/* rtl/fuzzy_gain_scheduled_pid.sv */
// Top level of the fuzzy gain-scheduled PID controller.
// An accepted request is registered by the front part, waits in the queue and is then
// handled by the back part's sequencer, one request at a time (a pop step, three
// restoring-division steps, integral update, multiply, drive saturation).
// The front part and the two-entry queue can absorb three more requests meanwhile.
// Reset (arst_n low, asynchronous) clears the integral, the held gains and all valid flags.
`include "fuzzy_gain_scheduled_pid_macros.svh"
module fuzzy_gain_scheduled_pid
	import fgsp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// err_sample [ERR_WIDTH-1:0], err_change [2*ERR_WIDTH-1:ERR_WIDTH]
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// drive [35:0], gain_p [38:36], gain_i [40:39], gain_d [42:41], zero padding above
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	// Front to queue.
	logic          push_valid;
	logic          push_ready;
	fgsp_item_t    push_item;

	// Queue to back.
	logic          pop_valid;
	logic          pop_ready;
	fgsp_item_t    pop_item;
	fgsp_fifo_st_t fifo_st;

	// Result fields as produced by the back part.
	logic signed [DRIVE_WIDTH-1:0] drive;
	logic [GP_W-1:0]               gain_p;
	logic [GI_W-1:0]               gain_i;
	logic [GD_W-1:0]               gain_d;

	// The front part registers each request, fuzzifies both error values, evaluates the
	// rule matrix and forms the weighted numerators and the common denominator.
	fgsp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_e       (s_tdata[ERR_WIDTH-1:0]),
		.in_de      (s_tdata[2*ERR_WIDTH-1:ERR_WIDTH]),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	// The queue lets the front keep taking requests while the back is busy dividing.
	fgsp_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item),
		.status     (fifo_st)
	);

	// The back part finds the gains by bit-serial division, keeps the previous gains when
	// no rule fires, saturates the integral and the drive, and holds the result in an
	// output register so that it can start on the next request while the result waits.
	fgsp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_drive  (drive),
		.out_gain_p (gain_p),
		.out_gain_i (gain_i),
		.out_gain_d (gain_d)
	);

	assign m_tdata = {{(OUT_TDATA_W-OUT_BITS){1'b0}}, gain_d, gain_i, gain_p, drive};

	// A weighted average of 2, 4 and 6 can never exceed 6.
	`FGSP_ASSERT_NOW(a_gain_p_range, m_tvalid, gain_p <= GP_W'(KP_L), "gain_p above its largest value")

	// The queue never holds more entries than it has.
	`FGSP_ASSERT_NOW(a_fifo_level, 1'b1, fifo_st.level <= FIFO_CNT_W'(FIFO_DEPTH), "queue level beyond its depth")

	// An accepted request is held by the front part in the next cycle.
	`FGSP_ASSERT_NEXT(a_front_capture, s_tvalid && s_tready, push_valid, "accepted request was lost by the front part")

	// Once the back part takes an entry, it is busy in the cycle after.
	`FGSP_ASSERT_NEXT(a_back_busy, pop_valid && pop_ready, !pop_ready, "back part took a second entry too early")

endmodule
